### src/gfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gfl_pkg;

	// request frame
	localparam int FRAME_LEN = 8;
	localparam int CNT_W     = $clog2(FRAME_LEN + 1);
	localparam int IDX_W     = $clog2(FRAME_LEN);
	localparam int STORE_N   = FRAME_LEN - 2;	// frame bytes 1 to 6
	localparam int DATE_N    = 5;

	localparam logic [7:0] HDR_RX  = 8'h55;
	localparam logic [7:0] HDR_TX0 = 8'haa;
	localparam logic [7:0] HDR_TX1 = 8'h01;
	localparam logic [7:0] PAD_TX  = 8'h00;

	// reply
	localparam int REPLY_LEN = 17;
	localparam int RIDX_W    = $clog2(REPLY_LEN);
	localparam int VAL_START = 8;	// first byte that needs the split values

	// result kinds
	localparam logic [1:0] KIND_REPLY    = 2'd0;
	localparam logic [1:0] KIND_ACCEPT   = 2'd1;
	localparam logic [1:0] KIND_CSUM_ERR = 2'd2;

	// divide by 1000 through a reciprocal: q = (x * DIV_MAGIC) >> DIV_SHIFT,
	// exact for every 32-bit x
	localparam int          CODE_W    = 32;
	localparam int          MAGIC_W   = 29;
	localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
	localparam int          DIV_SHIFT = 38;
	localparam int          PROD_W    = CODE_W + MAGIC_W;
	localparam int          Q_W       = PROD_W - DIV_SHIFT;
	localparam int          VAL_W     = 10;
	localparam logic [CODE_W-1:0] DIV_BASE = 32'd1000;
	localparam int          SPLIT_N   = 3;
	localparam int          SPLIT_CW  = $clog2(SPLIT_N);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		JOB_FRAME_OK,
		JOB_FRAME_ERR,
		JOB_SEND
	} job_kind_t;

	typedef struct packed {
		job_kind_t                    kind;
		logic [7:0]                   command;
		logic [DATE_N-1:0][7:0]       date;
		logic [CODE_W-1:0]            pressure_code;
		logic [CODE_W-1:0]            glucose_code;
	} job_t;

	typedef struct packed {
		logic                         done;
		logic [SPLIT_N-1:0][VAL_W-1:0] rem;
	} split_res_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [7:0]             tx_byte;
		logic                   last;
		logic [7:0]             command;
		logic [DATE_N-1:0][7:0] date;
	} res_t;

	typedef enum logic {
		BK_IDLE,
		BK_SEND
	} back_state_t;

endpackage

`default_nettype wire

### src/gfl_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface gfl_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [7:0]  rx_byte;
	logic [31:0] pressure_code;
	logic [31:0] glucose_code;

	modport source (output valid, operation, rx_byte, pressure_code, glucose_code,
		input ready);
	modport sink (input valid, operation, rx_byte, pressure_code, glucose_code,
		output ready);
endinterface

interface gfl_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] tx_byte;
	logic       last;
	logic [7:0] command;
	logic [7:0] year_byte;
	logic [7:0] month_byte;
	logic [7:0] day_byte;
	logic [7:0] hour_byte;
	logic [7:0] minute_byte;

	modport source (output valid, kind, tx_byte, last, command, year_byte,
		month_byte, day_byte, hour_byte, minute_byte, input ready);
	modport sink (input valid, kind, tx_byte, last, command, year_byte,
		month_byte, day_byte, hour_byte, minute_byte, output ready);
endinterface

`default_nettype wire

### src/gfl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gfl_front (
	input  wire logic      clk,
	input  wire logic      arst_n,
	gfl_req_if.sink        req,
	output gfl_pkg::job_t  push_data,
	output logic           push,
	input  wire logic      full
);

	logic [gfl_pkg::CNT_W-1:0]        cnt_q;
	logic [7:0]                       sum_q;
	logic [7:0]                       pend_q;
	logic [gfl_pkg::STORE_N-1:0][7:0] store_q;

	logic                      acc;
	logic                      acc_rx;
	logic                      acc_tx;
	logic                      hdr_bad;
	logic                      take;
	logic                      last_byte;
	logic [gfl_pkg::IDX_W-1:0] idx;

	assign req.ready = !full;
	assign acc       = req.valid && req.ready;
	assign acc_rx    = acc && !req.operation;
	assign acc_tx    = acc && req.operation;

	assign idx = (cnt_q >= gfl_pkg::CNT_W'(gfl_pkg::FRAME_LEN)) ? '0
		: cnt_q[gfl_pkg::IDX_W-1:0];
	assign hdr_bad   = (cnt_q == '0) && (req.rx_byte != gfl_pkg::HDR_RX);
	assign take      = acc_rx && (pend_q == '0) && !hdr_bad;
	assign last_byte = (idx == gfl_pkg::IDX_W'(gfl_pkg::FRAME_LEN - 1));

	assign push = acc_tx || (take && last_byte);

	always_comb begin
		push_data.command       = store_q[0];
		push_data.date          = store_q[gfl_pkg::STORE_N-1:1];
		push_data.pressure_code = req.pressure_code;
		push_data.glucose_code  = req.glucose_code;
		if (req.operation) begin
			push_data.kind = gfl_pkg::JOB_SEND;
		end else if (sum_q != req.rx_byte) begin
			push_data.kind = gfl_pkg::JOB_FRAME_ERR;
		end else begin
			push_data.kind = gfl_pkg::JOB_FRAME_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			pend_q  <= '0;
			store_q <= '0;
		end else if (acc_tx) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			pend_q  <= '0;
			store_q <= '0;
		end else if (take) begin
			if (!last_byte) begin
				// header byte is counted into the sum but not kept
				if (idx != '0) begin
					store_q[idx - 1'b1] <= req.rx_byte;
				end
				cnt_q <= gfl_pkg::CNT_W'(idx) + 1'b1;
				sum_q <= sum_q + req.rx_byte;
			end else if (sum_q != req.rx_byte) begin
				cnt_q   <= '0;
				sum_q   <= '0;
				pend_q  <= '0;
				store_q <= '0;
			end else begin
				pend_q <= store_q[0];
				if (store_q[0] == '0) begin
					cnt_q <= '0;
					sum_q <= '0;
				end else begin
					cnt_q <= gfl_pkg::CNT_W'(gfl_pkg::FRAME_LEN);
				end
			end
		end
	end

endmodule

`default_nettype wire

### src/gfl_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gfl_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire gfl_pkg::job_t  push_data,
	output logic                full,
	input  wire logic           pop,
	output gfl_pkg::job_t       pop_data,
	output logic                empty
);

	gfl_pkg::job_t               mem_q [gfl_pkg::QUEUE_DEPTH];
	logic [gfl_pkg::QPTR_W-1:0]  wr_q;
	logic [gfl_pkg::QPTR_W-1:0]  rd_q;
	logic [gfl_pkg::QCNT_W-1:0]  cnt_q;

	logic do_push;
	logic do_pop;

	assign full     = (cnt_q == gfl_pkg::QCNT_W'(gfl_pkg::QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == gfl_pkg::QPTR_W'(gfl_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == gfl_pkg::QPTR_W'(gfl_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/gfl_dec_split.sv
`timescale 1ns / 1ps
`default_nettype none

// Three successive divides by 1000, each done as a multiply by the
// reciprocal and then a take of quotient and remainder.
module gfl_dec_split (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [gfl_pkg::CODE_W-1:0]  code,
	output gfl_pkg::split_res_t              res
);

	logic [gfl_pkg::CODE_W-1:0]                    x_q;
	logic [gfl_pkg::PROD_W-1:0]                    prod_q;
	logic [gfl_pkg::SPLIT_N-1:0][gfl_pkg::VAL_W-1:0] rem_q;
	logic [gfl_pkg::SPLIT_CW-1:0]                  cnt_q;
	logic                                          run_q;
	logic                                          ph_q;
	logic                                          done_q;

	logic [gfl_pkg::Q_W-1:0]    quot;
	logic [gfl_pkg::CODE_W-1:0] diff;

	assign quot = prod_q[gfl_pkg::PROD_W-1:gfl_pkg::DIV_SHIFT];
	assign diff = x_q - gfl_pkg::CODE_W'(quot) * gfl_pkg::DIV_BASE;

	assign res.done = done_q;
	assign res.rem  = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= code;
		end else if (run_q && ph_q) begin
			x_q <= gfl_pkg::CODE_W'(quot);
		end
		if (run_q && !ph_q) begin
			prod_q <= gfl_pkg::PROD_W'(x_q) * gfl_pkg::PROD_W'(gfl_pkg::DIV_MAGIC);
		end
		if (run_q && ph_q) begin
			rem_q[cnt_q] <= diff[gfl_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ph_q   <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			run_q  <= 1'b1;
			ph_q   <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (run_q) begin
			ph_q <= !ph_q;
			if (ph_q) begin
				if (cnt_q == gfl_pkg::SPLIT_CW'(gfl_pkg::SPLIT_N - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### src/gfl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gfl_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gfl_pkg::job_t  job,
	input  wire logic           empty,
	output logic                pop,
	gfl_res_if.source           res
);

	gfl_pkg::back_state_t state_q;
	gfl_pkg::back_state_t state_d;

	logic [gfl_pkg::RIDX_W-1:0]        idx_q;
	logic [7:0]                        sum_q;
	logic [gfl_pkg::DATE_N-1:0][7:0]   date_q;
	gfl_pkg::res_t                     res_q;
	logic                              res_valid_q;

	gfl_pkg::split_res_t p_split;
	gfl_pkg::split_res_t g_split;

	logic                 can_load;
	logic                 start;
	logic                 load;
	logic                 emit;
	logic                 done_send;
	logic [7:0]           reply_byte;
	gfl_pkg::res_t        res_d;

	logic [gfl_pkg::VAL_W-1:0] glu;
	logic [gfl_pkg::VAL_W-1:0] sys;
	logic [gfl_pkg::VAL_W-1:0] dia;
	logic [gfl_pkg::VAL_W-1:0] hrt;

	gfl_dec_split u_psplit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.code   (job.pressure_code),
		.res    (p_split)
	);

	gfl_dec_split u_gsplit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.code   (job.glucose_code),
		.res    (g_split)
	);

	assign glu = g_split.rem[2];
	assign sys = p_split.rem[2];
	assign dia = p_split.rem[1];
	assign hrt = p_split.rem[0];

	assign can_load  = !res_valid_q || res.ready;
	assign done_send = (idx_q == gfl_pkg::RIDX_W'(gfl_pkg::REPLY_LEN - 1));

	always_comb begin
		case (idx_q)
			5'd1:    reply_byte = gfl_pkg::HDR_TX1;
			5'd2:    reply_byte = date_q[0];
			5'd3:    reply_byte = date_q[1];
			5'd4:    reply_byte = date_q[2];
			5'd5:    reply_byte = date_q[3];
			5'd6:    reply_byte = date_q[4];
			5'd7:    reply_byte = gfl_pkg::PAD_TX;
			5'd8:    reply_byte = {6'b0, glu[9:8]};
			5'd9:    reply_byte = glu[7:0];
			5'd10:   reply_byte = {6'b0, sys[9:8]};
			5'd11:   reply_byte = sys[7:0];
			5'd12:   reply_byte = {6'b0, dia[9:8]};
			5'd13:   reply_byte = dia[7:0];
			5'd14:   reply_byte = {6'b0, hrt[9:8]};
			5'd15:   reply_byte = hrt[7:0];
			5'd16:   reply_byte = sum_q;
			default: reply_byte = gfl_pkg::HDR_TX0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gfl_pkg::BK_IDLE: begin
				if (!empty && can_load && job.kind == gfl_pkg::JOB_SEND) begin
					state_d = gfl_pkg::BK_SEND;
				end
			end
			gfl_pkg::BK_SEND: begin
				if (emit && done_send) begin
					state_d = gfl_pkg::BK_IDLE;
				end
			end
			default: state_d = gfl_pkg::BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop   = 1'b0;
		start = 1'b0;
		load  = 1'b0;
		emit  = 1'b0;
		res_d = '0;
		case (state_q)
			gfl_pkg::BK_IDLE: begin
				if (!empty && can_load) begin
					pop  = 1'b1;
					load = 1'b1;
					case (job.kind)
						gfl_pkg::JOB_SEND: begin
							start         = 1'b1;
							res_d.kind    = gfl_pkg::KIND_REPLY;
							res_d.tx_byte = gfl_pkg::HDR_TX0;
						end
						gfl_pkg::JOB_FRAME_OK: begin
							res_d.kind    = gfl_pkg::KIND_ACCEPT;
							res_d.command = job.command;
							res_d.date    = job.date;
						end
						default: begin
							res_d.kind = gfl_pkg::KIND_CSUM_ERR;
						end
					endcase
				end
			end
			gfl_pkg::BK_SEND: begin
				if (can_load && (idx_q < gfl_pkg::RIDX_W'(gfl_pkg::VAL_START)
					|| (p_split.done && g_split.done))) begin
					emit          = 1'b1;
					load          = 1'b1;
					res_d.kind    = gfl_pkg::KIND_REPLY;
					res_d.tx_byte = reply_byte;
					res_d.last    = done_send;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
		if (start) begin
			date_q <= job.date;
			sum_q  <= gfl_pkg::HDR_TX0;
			idx_q  <= 5'd1;
		end else if (emit) begin
			sum_q <= sum_q + reply_byte;
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gfl_pkg::BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.kind        = res_q.kind;
	assign res.tx_byte     = res_q.tx_byte;
	assign res.last        = res_q.last;
	assign res.command     = res_q.command;
	assign res.year_byte   = res_q.date[0];
	assign res.month_byte  = res_q.date[1];
	assign res.day_byte    = res_q.date[2];
	assign res.hour_byte   = res_q.date[3];
	assign res.minute_byte = res_q.date[4];

endmodule

`default_nettype wire

### src/gateway_frame_link_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields                                           Accepted at
// -------  ---  -----------------------------------------------  ----------------------
// req      in   operation, rx_byte, pressure_code, glucose_code  req.valid && req.ready
// res      out  kind, tx_byte, last, command, five date bytes    res.valid && res.ready
//
// A received byte is taken when req.valid and req.ready meet; a finished
// frame gives one item through the job queue and the output register. A
// send item gives 17 reply items, one a cycle while the output takes them;
// the two reciprocal divide chains finish while the eight bytes ahead of the
// value bytes go out, so the value bytes never wait on them.
// Reset clears frame state, empties the job queue and drops the output valid at once.
// Input stalls only when the two-entry job queue is full; output stalls
// back-pressure the sequencer and then the queue.

module gateway_frame_link_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gfl_req_if.sink    req,
	gfl_res_if.source  res
);

	// front end: framing, checksum, lock and clear of the frame store
	gfl_pkg::job_t push_data;
	gfl_pkg::job_t pop_data;
	logic          push;
	logic          full;
	logic          pop;
	logic          empty;

	gfl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push_data (push_data),
		.push      (push),
		.full      (full)
	);

	// decoupling queue: front keeps taking bytes while a reply drains
	gfl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// back end: result items and the reply sequencer
	gfl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (pop_data),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

endmodule

`default_nettype wire
